// ===== hdl/r2h_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel pipeline.
`default_nettype none

package r2h_pkg;

  // Hue units: 1/64 degree, so one 60 degree sector is 3840 units
  localparam logic [14:0] SECTOR_UNITS  = 15'd3840;
  localparam logic [14:0] HUE_OFF_GREEN = 15'd7680;
  localparam logic [14:0] HUE_OFF_BLUE  = 15'd15360;
  localparam logic [14:0] FULL_CIRCLE   = 15'd23040;

  // Divider shape: 16 quotient bits, resolved four per stage
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;

  // Which channel holds the max (red wins ties, then green)
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // One restoring-division lane: partial remainder and a shift register
  // that holds leftover dividend bits on top and quotient bits below
  typedef struct packed {
    logic [7:0]        rem;
    logic [QUOT_W-1:0] num;
  } r2h_lane_t;

  // Everything that travels down the pipe with one pixel
  typedef struct packed {
    r2h_lane_t  lane_h;   // 3840 * |diff| / delta
    r2h_lane_t  lane_s;   // delta * 32768 / max
    logic [7:0] delta;
    logic [7:0] vmax;
    logic       neg;      // sign of the hue difference
    sector_e    sector;
  } r2h_work_t;

endpackage

`default_nettype wire

// ===== hdl/r2h_rgb_if.sv =====
// Channel interface carrying one RGB pixel per transaction.
`default_nettype none

interface r2h_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/r2h_hsv_if.sv =====
// Channel interface carrying one HSV pixel per transaction.
`default_nettype none

interface r2h_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/rgb_to_hsv_pixel_unit.sv =====
// RGB to HSV pixel converter: top level of a six-stage pipeline.
//
// Channels: pix_i takes one 8-bit RGB pixel per transaction; hsv_o gives
// hue (1/64 degree, 0..23039), saturation (Q1.15, 32768 = 1.0) and
// brightness (the largest channel). One result per pixel, in order.
// Path: a pixel accepted on pix_i passes one setup stage, four divider
// stages of four quotient bits each and one output stage, then is shown on
// hsv_o. Both quotients come from restoring dividers that resolve
// 16 bits over the four divider stages.
// Throughput: one pixel per cycle while hsv_o is taken.
// Stall: the whole pipe advances on one enable, high when the output
// register is empty or being taken; pix_i.ready follows that enable, so a
// stalled receiver freezes every stage and nothing is lost or repeated.
// Reset: rst_ni clears the valid bit of every stage; data registers are
// left as they are. There is no configuration.
`default_nettype none

module rgb_to_hsv_pixel_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  r2h_rgb_if.sink    pix_i,
  r2h_hsv_if.source  hsv_o
);
  import r2h_pkg::*;

  logic      en;
  logic      valid_s [0:DIV_STAGES];
  r2h_work_t work_s  [0:DIV_STAGES];

  // Global pipeline enable
  assign en          = !hsv_o.valid || hsv_o.ready;
  assign pix_i.ready = en;

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (valid_s[0]),
    .work_o  (work_s[0])
  );

  // Divider stages
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    r2h_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[s]),
      .work_i  (work_s[s]),
      .valid_o (valid_s[s+1]),
      .work_o  (work_s[s+1])
    );
  end

  r2h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (valid_s[DIV_STAGES]),
    .work_i       (work_s[DIV_STAGES]),
    .valid_o      (hsv_o.valid),
    .hue_o        (hsv_o.hue),
    .saturation_o (hsv_o.saturation),
    .brightness_o (hsv_o.brightness)
  );

  // Checks
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && !hsv_o.ready) |-> !pix_i.ready)
    else $error("input taken while output is stalled");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue < FULL_CIRCLE))
    else $error("hue out of range");

  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.saturation <= 16'd32768))
    else $error("saturation above 1.0");

  a_gray_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && hsv_o.saturation == 16'd0) |-> (hsv_o.hue == 15'd0))
    else $error("gray pixel with nonzero hue");

endmodule

`default_nettype wire

// ===== hdl/r2h_front.sv =====
// First stage: max/min, sector select and divider setup.
`default_nettype none

module r2h_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output logic                   valid_o,
  output r2h_pkg::r2h_work_t     work_o
);
  import r2h_pkg::*;

  logic        valid_q;
  r2h_work_t   work_d, work_q;
  logic [7:0]  vmax, vmin, mag;
  logic [8:0]  diff;
  logic [19:0] num_h;
  sector_e     sector;

  // Max, min and the winning channel
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sector = SEC_RED;
      vmax   = red_i;
      diff   = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      sector = SEC_GREEN;
      vmax   = green_i;
      diff   = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sector = SEC_BLUE;
      vmax   = blue_i;
      diff   = {1'b0, red_i} - {1'b0, green_i};
    end
    vmin = red_i;
    if (green_i < vmin) vmin = green_i;
    if (blue_i < vmin)  vmin = blue_i;
  end

  // |diff| * 3840, with 3840 = 4096 - 256
  assign mag   = diff[8] ? 8'(-diff) : diff[7:0];
  assign num_h = {mag, 12'b0} - {4'b0, mag, 8'b0};

  // Seed both lanes; the top dividend bits are already below the divisor
  always_comb begin
    work_d.sector     = sector;
    work_d.neg        = diff[8];
    work_d.vmax       = vmax;
    work_d.delta      = vmax - vmin;
    work_d.lane_h.rem = {4'b0, num_h[19:16]};
    work_d.lane_h.num = num_h[15:0];
    work_d.lane_s.rem = {1'b0, work_d.delta[7:1]};
    work_d.lane_s.num = {work_d.delta[0], {(QUOT_W-1){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ===== hdl/r2h_div_stage.sv =====
// One divider stage: four restoring steps on the hue and saturation lanes.
`default_nettype none

module r2h_div_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire r2h_pkg::r2h_work_t work_i,
  output logic                    valid_o,
  output r2h_pkg::r2h_work_t      work_o
);
  import r2h_pkg::*;

  logic      valid_q;
  r2h_work_t work_d, work_q;

  // Shift in one dividend bit, subtract the divisor if it fits
  function automatic r2h_lane_t div_step(r2h_lane_t lane, logic [7:0] dvs);
    logic [8:0] trial;
    r2h_lane_t  res;
    trial = {lane.rem, lane.num[QUOT_W-1]};
    if (trial >= {1'b0, dvs}) begin
      res.rem = 8'(trial - {1'b0, dvs});
      res.num = {lane.num[QUOT_W-2:0], 1'b1};
    end else begin
      res.rem = trial[7:0];
      res.num = {lane.num[QUOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  always_comb begin
    work_d = work_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      work_d.lane_h = div_step(work_d.lane_h, work_i.delta);
      work_d.lane_s = div_step(work_d.lane_s, work_i.vmax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ===== hdl/r2h_back.sv =====
// Last stage: sector offset, sign, hue wrap, gray check; output register.
`default_nettype none

module r2h_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire r2h_pkg::r2h_work_t work_i,
  output logic                    valid_o,
  output logic [14:0]             hue_o,
  output logic [15:0]             saturation_o,
  output logic [7:0]              brightness_o
);
  import r2h_pkg::*;

  logic               valid_q;
  logic [14:0]        hue_d, hue_q;
  logic [15:0]        sat_d, sat_q;
  logic [7:0]         bright_q;
  logic [14:0]        offset;
  logic signed [15:0] frac, sum;
  logic               gray;

  assign gray = (work_i.delta == 8'd0);

  always_comb begin
    case (work_i.sector)
      SEC_RED:   offset = 15'd0;
      SEC_GREEN: offset = HUE_OFF_GREEN;
      SEC_BLUE:  offset = HUE_OFF_BLUE;
      default:   offset = 15'd0;
    endcase
  end

  // Signed fraction plus offset; only the red sector can go negative
  always_comb begin
    frac = $signed({4'b0, work_i.lane_h.num[11:0]});
    if (work_i.neg) frac = -frac;
    sum = $signed({1'b0, offset}) + frac;
    if (sum[15]) sum = sum + $signed({1'b0, FULL_CIRCLE});
    hue_d = gray ? 15'd0 : sum[14:0];
    sat_d = gray ? 16'd0 : work_i.lane_s.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= work_i.vmax;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the RGB to HSV pixel converter.
`default_nettype none

module tb;
  import r2h_pkg::*;

  localparam int SAT_ONE     = 32768;
  localparam int RUN_LIMIT   = 4_000_000;
  localparam int DRAIN_EDGES = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
  } hsv_pix_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Values driven into the channels, known from time zero
  logic     drv_valid = 1'b0;
  rgb_pix_t drv_pix   = '0;
  logic     drv_ready = 1'b0;

  r2h_rgb_if pix ();
  r2h_hsv_if hsv ();

  assign pix.valid = drv_valid;
  assign pix.red   = drv_pix.red;
  assign pix.green = drv_pix.green;
  assign pix.blue  = drv_pix.blue;
  assign hsv.ready = drv_ready;

  rgb_to_hsv_pixel_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  rgb_pix_t pixel_in_q[$];
  hsv_pix_t hsv_due_q[$];
  rgb_pix_t next_pix;
  hsv_pix_t hsv_got;
  hsv_pix_t hsv_want;
  bit       bus_full = 1'b0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       hsv_errors     = 0;

  // Fixed-point HSV of one pixel; red wins ties for the max, then green
  function automatic hsv_pix_t hsv_of_rgb(rgb_pix_t p);
    int       r;
    int       g;
    int       b;
    int       mx;
    int       mn;
    int       dl;
    int       hue_v;
    int       sat_v;
    sector_e  sec;
    hsv_pix_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    sec = (mx == r) ? SEC_RED : ((mx == g) ? SEC_GREEN : SEC_BLUE);
    hue_v = 0;
    sat_v = 0;
    if (dl > 0) begin
      // int division truncates toward zero, as the hardware quotient does
      case (sec)
        SEC_RED: begin
          hue_v = int'(SECTOR_UNITS) * (g - b) / dl;
        end
        SEC_GREEN: begin
          hue_v = int'(HUE_OFF_GREEN) + int'(SECTOR_UNITS) * (b - r) / dl;
        end
        default: begin
          hue_v = int'(HUE_OFF_BLUE) + int'(SECTOR_UNITS) * (r - g) / dl;
        end
      endcase
      if (hue_v < 0) hue_v += int'(FULL_CIRCLE);
      sat_v = dl * SAT_ONE / mx;
    end
    res.hue        = hue_v[14:0];
    res.saturation = sat_v[15:0];
    res.brightness = mx[7:0];
    return res;
  endfunction

  task automatic push_pixel(input int r, input int g, input int b);
    rgb_pix_t p;
    p.red   = r[7:0];
    p.green = g[7:0];
    p.blue  = b[7:0];
    pixel_in_q.push_back(p);
  endtask

  // Random pixel, biased toward gray, ties for the max and saturated channels
  task automatic push_random_pixel();
    int mode;
    int hi;
    int lo;
    int ch[3];
    mode = $urandom_range(7);
    case (mode)
      0: begin
        hi = $urandom_range(255);
        push_pixel(hi, hi, hi);
      end
      1: begin
        hi = $urandom_range(255);
        lo = $urandom_range(hi);
        case ($urandom_range(2))
          0: push_pixel(hi, hi, lo);
          1: push_pixel(hi, lo, hi);
          default: push_pixel(lo, hi, hi);
        endcase
      end
      2: begin
        foreach (ch[i]) begin
          case ($urandom_range(2))
            0: ch[i] = 0;
            1: ch[i] = 255;
            default: ch[i] = $urandom_range(255);
          endcase
        end
        push_pixel(ch[0], ch[1], ch[2]);
      end
      default: begin
        push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    endcase
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Input driver and output ready, both updated on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!bus_full) begin
        if (pixel_in_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pix = pixel_in_q.pop_front();
          drv_pix   <= next_pix;
          drv_valid <= 1'b1;
          bus_full = 1'b1;
        end else begin
          drv_pix   <= rgb_pix_t'($urandom);
          drv_valid <= 1'b0;
        end
      end
      drv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Record accepted pixels and check each HSV transaction in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        hsv_due_q.push_back(hsv_of_rgb({pix.red, pix.green, pix.blue}));
        bus_full = 1'b0;
      end
      if (hsv.valid && hsv.ready) begin
        hsv_got = {hsv.hue, hsv.saturation, hsv.brightness};
        if (hsv_due_q.size() == 0) begin
          hsv_errors++;
          $display("%0t unexpected transaction: got hue %0d sat %0d val %0d",
                   $time, hsv_got.hue, hsv_got.saturation, hsv_got.brightness);
        end else begin
          hsv_want = hsv_due_q.pop_front();
          if (hsv_got.hue !== hsv_want.hue ||
              hsv_got.saturation !== hsv_want.saturation ||
              hsv_got.brightness !== hsv_want.brightness) begin
            hsv_errors++;
            $display("%0t mismatch: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                     $time, hsv_want.hue, hsv_want.saturation, hsv_want.brightness,
                     hsv_got.hue, hsv_got.saturation, hsv_got.brightness);
          end
        end
      end
    end
  end

  // Stimulus: directed corners, then random pixels over four idling phases
  initial begin
    int phase_send[4];
    int phase_recv[4];
    phase_send = '{0, 56, 0, 37};
    phase_recv = '{0, 0, 56, 37};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // gray and black
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(128, 128, 128);
    // primaries and single-count saturation of 1.0
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 0);
    push_pixel(0, 0, 255);
    push_pixel(1, 0, 0);
    // ties for the max
    push_pixel(255, 255, 0);
    push_pixel(255, 0, 255);
    push_pixel(0, 255, 255);
    push_pixel(170, 170, 85);
    // red sector going negative, wraps below 360 degrees
    push_pixel(255, 0, 1);
    push_pixel(255, 0, 254);
    push_pixel(200, 50, 100);
    // small delta
    push_pixel(255, 254, 254);
    push_pixel(254, 255, 254);
    push_pixel(254, 254, 255);
    // each sector, green and blue with either sign of the difference
    push_pixel(200, 100, 50);
    push_pixel(50, 200, 100);
    push_pixel(100, 200, 50);
    push_pixel(100, 50, 200);
    push_pixel(50, 100, 200);
    push_pixel(0, 1, 255);
    push_pixel(254, 255, 0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      repeat (ph == 0 ? 280 : 300) push_random_pixel();
      while (pixel_in_q.size() != 0 || bus_full) @(posedge clk_i);
    end

    // Drain with the receiver always ready
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (hsv_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_EDGES) @(posedge clk_i);
    if (hsv_errors == 0 && hsv_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
